>>> rtl/core/hexb_pkg.sv
// ============================================================================
// hexb_pkg
// Shared types, character codes and classification helpers for the hex text
// to bytes parser.
// ============================================================================
`default_nettype none

package hexb_pkg;

    // Actions passed from the front (character classifier) to the back
    localparam logic [1:0] ACT_DIGIT = 2'd0;
    localparam logic [1:0] ACT_SEP   = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] nib;
        logic       bad;
        logic       inv;
    } hexb_act_t;

    // Action queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    // Offsets that turn a hex letter into its nibble value
    localparam logic [7:0] LO_HEX_OFS = 8'h57;
    localparam logic [7:0] UP_HEX_OFS = 8'h37;

    // Error flag bits
    localparam int FLAG_INV  = 0;
    localparam int FLAG_BAD  = 1;
    localparam int FLAG_LONG = 2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_LONG    = 2'd3;

    // Result kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    function automatic logic is_x(input logic [7:0] c);
        return (c == CH_LO_X) || (c == CH_UP_X);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
               ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
               ((c >= CH_ZERO) && (c <= CH_NINE));
    endfunction

    // Returns {bad, nibble}; a non-hex letter reads as zero with bad set
    function automatic logic [4:0] char_nibble(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'h10;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            d = c - CH_ZERO;
            r = {1'b0, d[3:0]};
        end else if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
            d = c - LO_HEX_OFS;
            r = {1'b0, d[3:0]};
        end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
            d = c - UP_HEX_OFS;
            r = {1'b0, d[3:0]};
        end
        return r;
    endfunction

    // Invalid character wins, then bad digit, then word too long
    function automatic logic [1:0] status_of(input logic [2:0] flags);
        logic [1:0] s;
        s = ST_OK;
        if (flags[FLAG_INV]) begin
            s = ST_INVALID;
        end else if (flags[FLAG_BAD]) begin
            s = ST_BAD;
        end else if (flags[FLAG_LONG]) begin
            s = ST_LONG;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/hexb_front.sv
// ============================================================================
// hexb_front
// Character window and classifier: resolves the "0x" separator lookahead and
// turns each character, or each "0x" pair, into one action for the back end.
// ============================================================================
`default_nettype none

module hexb_front
    import hexb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       act_push,
    output hexb_act_t  act,
    input  logic       act_full
);

    logic [7:0] win_reg  [4];
    logic [7:0] win_next [4];
    logic [2:0] cnt_reg, cnt_next;
    logic       last_reg, last_next;

    logic       act_valid;
    logic [1:0] adv;
    logic [1:0] cons;
    logic [2:0] left;
    logic       head_zero;
    logic       next_x;
    logic [4:0] nib_info;
    logic       accept;

    assign head_zero = (win_reg[0] == CH_ZERO);
    assign next_x    = is_x(win_reg[1]);
    assign nib_info  = char_nibble(win_reg[0]);

    // Decide the action for the head of the window
    always_comb begin
        act       = '0;
        act_valid = 1'b0;
        adv       = 2'd0;
        if (cnt_reg == 3'd0) begin
            if (last_reg) begin
                act_valid = 1'b1;
                act.kind  = ACT_END;
            end
        end else if (head_zero && next_x && (cnt_reg == 3'd4)) begin
            // drop the "0x" pair, it only separates words
            act_valid = 1'b1;
            act.kind  = ACT_SEP;
            adv       = 2'd2;
        end else if (head_zero && !last_reg && ((cnt_reg == 3'd1) || next_x)) begin
            // hold: not enough followers known yet
            act_valid = 1'b0;
        end else begin
            act_valid = 1'b1;
            adv       = 2'd1;
            if (is_alnum(win_reg[0])) begin
                act.kind = ACT_DIGIT;
                act.nib  = nib_info[3:0];
                act.bad  = nib_info[4];
            end else begin
                act.kind = ACT_SEP;
                act.inv  = (win_reg[0] != CH_SPACE) && (win_reg[0] != CH_COMMA);
            end
        end
    end

    assign act_push   = act_valid && !act_full;
    assign cons       = act_push ? adv : 2'd0;
    assign left       = cnt_reg - {1'b0, cons};
    assign char_ready = !last_reg && (left != 3'd4);
    assign accept     = char_valid && char_ready;

    always_comb begin
        case (cons)
            2'd1: begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = win_reg[3];
                win_next[3] = win_reg[3];
            end
            2'd2: begin
                win_next[0] = win_reg[2];
                win_next[1] = win_reg[3];
                win_next[2] = win_reg[3];
                win_next[3] = win_reg[3];
            end
            default: begin
                win_next = win_reg;
            end
        endcase
        if (accept) begin
            for (int i = 0; i < 4; i++) begin
                if (left[1:0] == 2'(i)) begin
                    win_next[i] = char_code;
                end
            end
        end
        cnt_next  = left + {2'b00, accept};
        last_next = last_reg;
        if (act_push && (act.kind == ACT_END)) begin
            last_next = 1'b0;
        end
        if (accept) begin
            last_next = last_char;
        end
    end

    always_ff @(posedge clk) begin
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg  <= 3'd0;
            last_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hexb_queue.sv
// ============================================================================
// hexb_queue
// Short action queue that decouples the classifier from the word back end.
// ============================================================================
`default_nettype none

module hexb_queue
    import hexb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hexb_act_t push_data,
    output logic      full,
    input  logic      pop,
    output hexb_act_t pop_data,
    output logic      valid
);

    hexb_act_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]      count_reg, count_next;

    assign full     = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + {{QUEUE_AW{1'b0}}, push} - {{QUEUE_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hexb_back.sv
// ============================================================================
// hexb_back
// Word back end: buffers digits, flushes words as bytes, applies the byte
// limit and emits the final summary through an output register.
// ============================================================================
`default_nettype none

module hexb_back
    import hexb_pkg::*;
#(
    parameter int MAX_WORD_CHARS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  hexb_act_t   q_act,
    output logic        q_pop,
    input  logic [15:0] max_bytes,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        result_kind,
    output logic [7:0]  byte_value,
    output logic [1:0]  status,
    output logic [15:0] total_bytes,
    output logic        last_result
);

    localparam int AW = $clog2(MAX_WORD_CHARS);
    localparam int LW = $clog2(MAX_WORD_CHARS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ODD  = 3'd1;
    localparam logic [2:0] S_LO   = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;

    logic [3:0]    word_mem [MAX_WORD_CHARS];
    logic [3:0]    rdata_reg;

    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [3:0]    hi_reg, hi_next;
    logic [2:0]    flags_reg, flags_next;
    logic [15:0]   total_reg, total_next;
    logic          end_reg, end_next;

    logic          ov_reg, ov_next;
    logic          okind_reg, okind_next;
    logic [7:0]    obyte_reg, obyte_next;
    logic [1:0]    ostat_reg, ostat_next;
    logic [15:0]   otot_reg, otot_next;
    logic          olast_reg, olast_next;

    logic          mem_we;
    logic [AW-1:0] rd_addr;
    logic          can_load;
    logic          under;
    logic          prod;
    logic [7:0]    pbyte;
    logic          go;
    logic [LW:0]   idx_p1;
    logic [LW:0]   idx_p2;
    logic [2:0]    done_state;

    assign can_load   = !ov_reg || res_ready;
    assign under      = (total_reg < max_bytes);
    assign idx_p1     = {1'b0, idx_reg} + (LW + 1)'(1);
    assign idx_p2     = {1'b0, idx_reg} + (LW + 1)'(2);
    assign done_state = end_reg ? S_SUM : S_IDLE;
    // a suppressed byte needs no room in the output register
    assign go         = prod && (!under || can_load);

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        hi_next    = hi_reg;
        flags_next = flags_reg;
        total_next = total_reg;
        end_next   = end_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        prod       = 1'b0;
        pbyte      = 8'h00;

        ov_next    = ov_reg && !res_ready;
        okind_next = okind_reg;
        obyte_next = obyte_reg;
        ostat_next = ostat_reg;
        otot_next  = otot_reg;
        olast_next = olast_reg;

        case (state_reg)
            S_IDLE: begin
                rd_addr = '0;
                q_pop   = q_valid;
                if (q_valid) begin
                    case (q_act.kind)
                        ACT_DIGIT: begin
                            if (q_act.bad) begin
                                flags_next[FLAG_BAD] = 1'b1;
                            end
                            if (len_reg < LW'(MAX_WORD_CHARS)) begin
                                mem_we   = 1'b1;
                                len_next = len_reg + LW'(1);
                            end else begin
                                flags_next[FLAG_LONG] = 1'b1;
                            end
                        end
                        ACT_SEP, ACT_END: begin
                            if (q_act.inv) begin
                                flags_next[FLAG_INV] = 1'b1;
                            end
                            end_next = (q_act.kind == ACT_END);
                            idx_next = '0;
                            if (len_reg == '0) begin
                                state_next = (q_act.kind == ACT_END) ? S_SUM : S_IDLE;
                            end else if (len_reg[0]) begin
                                state_next = S_ODD;
                            end else begin
                                state_next = S_LO;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ODD: begin
                // lone leading digit of an odd-length word
                prod  = 1'b1;
                pbyte = {4'h0, rdata_reg};
                if (go) begin
                    idx_next = LW'(1);
                    rd_addr  = AW'(1);
                    if (len_reg == LW'(1)) begin
                        len_next   = '0;
                        state_next = done_state;
                    end else begin
                        state_next = S_LO;
                    end
                end
            end
            S_LO: begin
                hi_next    = rdata_reg;
                rd_addr    = idx_p1[AW-1:0];
                state_next = S_OUT;
            end
            S_OUT: begin
                prod    = 1'b1;
                pbyte   = {hi_reg, rdata_reg};
                rd_addr = idx_p1[AW-1:0];
                if (go) begin
                    if (idx_p2 == {1'b0, len_reg}) begin
                        len_next   = '0;
                        state_next = done_state;
                    end else begin
                        idx_next   = idx_p2[LW-1:0];
                        rd_addr    = idx_p2[AW-1:0];
                        state_next = S_LO;
                    end
                end
            end
            S_SUM: begin
                if (can_load) begin
                    ov_next    = 1'b1;
                    okind_next = KIND_SUMMARY;
                    obyte_next = 8'h00;
                    ostat_next = status_of(flags_reg);
                    otot_next  = total_reg;
                    olast_next = 1'b1;
                    flags_next = '0;
                    total_next = '0;
                    end_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (go) begin
            if (total_reg != 16'hFFFF) begin
                total_next = total_reg + 16'd1;
            end
            if (under) begin
                ov_next    = 1'b1;
                okind_next = KIND_DATA;
                obyte_next = pbyte;
                ostat_next = ST_OK;
                otot_next  = '0;
                olast_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (mem_we) begin
            word_mem[len_reg[AW-1:0]] <= q_act.nib;
        end
        rdata_reg <= word_mem[rd_addr];
    end

    always_ff @(posedge clk) begin
        idx_reg   <= idx_next;
        hi_reg    <= hi_next;
        okind_reg <= okind_next;
        obyte_reg <= obyte_next;
        ostat_reg <= ostat_next;
        otot_reg  <= otot_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            flags_reg <= '0;
            total_reg <= '0;
            end_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            flags_reg <= flags_next;
            total_reg <= total_next;
            end_reg   <= end_next;
            ov_reg    <= ov_next;
        end
    end

    assign res_valid   = ov_reg;
    assign result_kind = okind_reg;
    assign byte_value  = obyte_reg;
    assign status      = ostat_reg;
    assign total_bytes = otot_reg;
    assign last_result = olast_reg;

endmodule

`default_nettype wire

>>> rtl/core/hex_text_to_bytes_core.sv
// ============================================================================
// hex_text_to_bytes_core
// Streaming hex text parser: one ASCII character per word in, data bytes and
// one closing summary per string out.
// ============================================================================
//
//  Channel   Handshake              Payload                       Dir
//  -------   --------------------   ---------------------------   ---
//  char      char_valid/ready       char_code, last_char          in
//  res       res_valid/ready        result_kind, byte_value,      out
//                                   status, total_bytes,
//                                   last_result
//  config    max_bytes_we           max_bytes_wdata               in
//
//  Flow: the front takes one character per cycle while its window has room
//  and no final character waits, and turns each windowed character or "0x"
//  pair into one action. The back retires a digit action in S_IDLE; a word
//  flush runs S_LO then S_OUT per byte (one word-buffer read port, one nibble
//  per read), S_ODD for a lone leading digit, then S_SUM for the summary.
//  Reset: rst_n clears the character window, the action queue, word length,
//  error flags, byte count and output valid; the word buffer is not cleared.
//  Stalls: a full output register stalls the back only; the four-entry action
//  queue keeps the front taking characters until it fills.
//
`default_nettype none

module hex_text_to_bytes_core
    import hexb_pkg::*;
#(
    parameter int MAX_WORD_CHARS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // character channel
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    // result channel
    output logic        res_valid,
    input  logic        res_ready,
    output logic        result_kind,
    output logic [7:0]  byte_value,
    output logic [1:0]  status,
    output logic [15:0] total_bytes,
    output logic        last_result,
    // configuration
    input  logic        max_bytes_we,
    input  logic [15:0] max_bytes_wdata
);

    logic [15:0] max_bytes_reg, max_bytes_next;

    hexb_act_t   front_act;
    hexb_act_t   q_act;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;

    // Byte limit register; the user must write it only while the block is idle, the block does not enforce this
    always_comb begin
        max_bytes_next = max_bytes_we ? max_bytes_wdata : max_bytes_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_bytes_reg <= 16'hFFFF;
        end else begin
            max_bytes_reg <= max_bytes_next;
        end
    end

    // Front: hold up to four characters so a '0' can wait for its followers,
    // then classify the head character into a digit, separator or end action.
    hexb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .act_push   (q_push),
        .act        (front_act),
        .act_full   (q_full)
    );

    // Queue: absorb actions while the back is busy flushing a word
    hexb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_act),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_act),
        .valid     (q_valid)
    );

    // Back: buffer digits, emit bytes on each separator, count against the
    // limit and close the string with the summary result.
    hexb_back #(
        .MAX_WORD_CHARS (MAX_WORD_CHARS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_act       (q_act),
        .q_pop       (q_pop),
        .max_bytes   (max_bytes_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .result_kind (result_kind),
        .byte_value  (byte_value),
        .status      (status),
        .total_bytes (total_bytes),
        .last_result (last_result)
    );

`ifndef SYNTH
    // Never push into a full action queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("action pushed into full queue");

    // Never pop an empty action queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("action popped from empty queue");

    // After the final character, hold off new characters until the end action
    a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_ready && last_char) |=> !char_ready)
        else $error("character taken behind final character");

    // Data results carry no status and no count
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (result_kind == KIND_DATA)) |->
        ((status == ST_OK) && (total_bytes == 16'd0) && !last_result))
        else $error("data result carries summary fields");
`endif

endmodule

`default_nettype wire
